>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, checks suspended while reset is high
`define TCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on the next clock edge
`define TCM_ASSERT_NEXT(label, ante, cons, msg) \
   `TCM_ASSERT(label, (ante) |=> (cons), msg)

// implication checked on the same clock edge
`define TCM_ASSERT_SAME(label, ante, cons, msg) \
   `TCM_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/tcm_pkg.sv
package tcm_pkg;

   localparam int DATA_W     = 32;
   localparam int KIND_W     = 2;
   localparam int INDEX_W    = 4;
   localparam int CLK_CTRL_W = 5;
   localparam int CNT_CTRL_W = 7;
   localparam int STATUS_W   = 5;
   localparam int ENABLE_W   = 6;
   localparam int MATCH_NUM  = 3;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

   // register map
   localparam logic [INDEX_W-1:0] REG_CLK_CTRL = 4'd0;
   localparam logic [INDEX_W-1:0] REG_CNT_CTRL = 4'd1;
   localparam logic [INDEX_W-1:0] REG_COUNT    = 4'd2;
   localparam logic [INDEX_W-1:0] REG_INTERVAL = 4'd3;
   localparam logic [INDEX_W-1:0] REG_MATCH0   = 4'd4;
   localparam logic [INDEX_W-1:0] REG_MATCH1   = 4'd5;
   localparam logic [INDEX_W-1:0] REG_MATCH2   = 4'd6;
   localparam logic [INDEX_W-1:0] REG_STATUS   = 4'd7;
   localparam logic [INDEX_W-1:0] REG_ENABLE   = 4'd8;

   // clock control bits
   localparam int CC_PS_EN_BIT = 0;

   // counter control bits
   localparam int CT_STOP_BIT     = 0;
   localparam int CT_INTV_BIT     = 1;
   localparam int CT_DECR_BIT     = 2;
   localparam int CT_MATCH_BIT    = 3;
   localparam int CT_RST_BIT      = 4;
   localparam int CT_WAVE_DIS_BIT = 5;
   localparam int CT_POL_BIT      = 6;

   // interrupt status bits
   localparam int IS_INTV_BIT   = 0;
   localparam int IS_MATCH0_BIT = 1;
   localparam int IS_OVR_BIT    = 4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] reg_index;
      logic [DATA_W-1:0]  write_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic              wave_out;
   } rsp_item_type;

endpackage

>>> rtl/timer_counter_with_match_top.sv
// one timer channel with prescaler, interval/overflow wrap and three match registers
// request channel: req_valid/req_stall carry a transaction of req_kind (tick, read,
// write), req_reg_index and req_write_data; one response per request
// response channel: rsp_valid/rsp_stall carry rsp_read_data (register value on
// reads, zero otherwise), rsp_irq and rsp_wave_out as they stand after the request
// a request taken into the input register moves on into the response register
// once that register is empty or being taken, and rsp_valid then shows it
// throughput: one request per cycle while rsp_stall is low; the input register
// feeds one pass of counter, prescaler and register-file logic into the
// response register
// reset (synchronous, active high) empties both registers, clears all timer
// registers and leaves the counter stopped
// when rsp_stall holds the response, the input register keeps taking one more
// request, then req_stall rises until the response is taken; nothing is dropped
module timer_counter_with_match_top
   import tcm_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int PRESCALE_BITS = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [INDEX_W-1:0]   req_reg_index,
   input  logic [DATA_W-1:0]    req_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_W-1:0]    rsp_read_data,
   output logic                 rsp_irq,
   output logic                 rsp_wave_out
);

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   rsp_item_type result;
   rsp_item_type rsp_item;

   assign req_item.kind       = req_kind;
   assign req_item.reg_index  = req_reg_index;
   assign req_item.write_data = req_write_data;

   tcm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tcm_core #(
      .COUNT_BITS    (COUNT_BITS),
      .PRESCALE_BITS (PRESCALE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (item_valid && advance),
      .item   (item),
      .result (result)
   );

   tcm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_read_data = rsp_item.read_data;
   assign rsp_irq       = rsp_item.irq;
   assign rsp_wave_out  = rsp_item.wave_out;

endmodule

>>> rtl/tcm_in_reg.sv
`include "assert_macros.svh"

module tcm_in_reg
   import tcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // a held transaction must not be lost or overwritten
   `TCM_ASSERT_NEXT(a_hold_item, !reset && req_stall, valid_ff && $stable(item_ff), "held transaction changed")

endmodule

>>> rtl/tcm_core.sv
`include "assert_macros.svh"

module tcm_core
   import tcm_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int PRESCALE_BITS = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam int PS_W = 1 << PRESCALE_BITS;

   logic [PS_W-1:0]       ps_ff, ps_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CLK_CTRL_W-1:0] clk_ctrl_ff, clk_ctrl_in;
   logic [CNT_CTRL_W-1:0] cnt_ctrl_ff, cnt_ctrl_in;
   logic [COUNT_BITS-1:0] interval_ff, interval_in;
   logic [COUNT_BITS-1:0] match_ff [MATCH_NUM];
   logic [COUNT_BITS-1:0] match_in [MATCH_NUM];
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ENABLE_W-1:0]   enable_ff, enable_in;
   logic                  wave_ff, wave_in;

   logic [PRESCALE_BITS-1:0] ps_n;
   logic [PS_W-1:0]          ps_last;
   logic [COUNT_BITS-1:0]    cnt_top;
   logic [COUNT_BITS-1:0]    cnt_adv;
   logic                     adv_wrap;
   logic [MATCH_NUM-1:0]     hit;
   logic                     adv;
   logic [DATA_W-1:0]        rd;
   logic [CNT_CTRL_W-1:0]    ctrl_wr;

   // prescaler terminal count: low n+1 bits set
   assign ps_n = clk_ctrl_ff[PRESCALE_BITS:1];
   always_comb begin
      for (int i = 0; i < PS_W; i++) begin
         ps_last[i] = (PRESCALE_BITS'(i) <= ps_n);
      end
   end

   // next count, wrap flag and match hits if the counter advances
   always_comb begin
      cnt_top  = cnt_ctrl_ff[CT_INTV_BIT] ? interval_ff : '1;
      adv_wrap = 1'b0;
      if (cnt_ctrl_ff[CT_DECR_BIT]) begin
         if (cnt_ff == '0) begin
            cnt_adv  = cnt_top;
            adv_wrap = 1'b1;
         end else begin
            cnt_adv = cnt_ff - COUNT_BITS'(1);
         end
      end else begin
         if (cnt_ff >= cnt_top) begin
            cnt_adv  = '0;
            adv_wrap = 1'b1;
         end else begin
            cnt_adv = cnt_ff + COUNT_BITS'(1);
         end
      end
      for (int i = 0; i < MATCH_NUM; i++) begin
         hit[i] = (cnt_adv == match_ff[i]);
      end
   end

   always_comb begin
      ps_in       = ps_ff;
      cnt_in      = cnt_ff;
      clk_ctrl_in = clk_ctrl_ff;
      cnt_ctrl_in = cnt_ctrl_ff;
      interval_in = interval_ff;
      match_in    = match_ff;
      status_in   = status_ff;
      enable_in   = enable_ff;
      wave_in     = wave_ff;
      adv         = 1'b0;
      rd          = '0;
      ctrl_wr     = item.write_data[CNT_CTRL_W-1:0];

      case (item.kind)
         KIND_TICK: begin
            if (!cnt_ctrl_ff[CT_STOP_BIT]) begin
               if (clk_ctrl_ff[CC_PS_EN_BIT]) begin
                  if (ps_ff >= ps_last) begin
                     ps_in = '0;
                     adv   = 1'b1;
                  end else begin
                     ps_in = ps_ff + PS_W'(1);
                  end
               end else begin
                  ps_in = '0;
                  adv   = 1'b1;
               end
            end
         end
         KIND_READ: begin
            case (item.reg_index)
               REG_CLK_CTRL: rd = DATA_W'(clk_ctrl_ff);
               REG_CNT_CTRL: rd = DATA_W'(cnt_ctrl_ff);
               REG_COUNT:    rd = DATA_W'(cnt_ff);
               REG_INTERVAL: rd = DATA_W'(interval_ff);
               REG_MATCH0:   rd = DATA_W'(match_ff[0]);
               REG_MATCH1:   rd = DATA_W'(match_ff[1]);
               REG_MATCH2:   rd = DATA_W'(match_ff[2]);
               REG_STATUS: begin
                  rd        = DATA_W'(status_ff);
                  status_in = '0;
               end
               REG_ENABLE:   rd = DATA_W'(enable_ff);
               default:      rd = '0;
            endcase
         end
         KIND_WRITE: begin
            case (item.reg_index)
               REG_CLK_CTRL: clk_ctrl_in = item.write_data[CLK_CTRL_W-1:0];
               REG_CNT_CTRL: begin
                  // reset bit clears count and prescaler, never stored
                  if (ctrl_wr[CT_RST_BIT]) begin
                     cnt_in = '0;
                     ps_in  = '0;
                  end
                  cnt_ctrl_in             = ctrl_wr;
                  cnt_ctrl_in[CT_RST_BIT] = 1'b0;
               end
               REG_INTERVAL: interval_in = item.write_data[COUNT_BITS-1:0];
               REG_MATCH0:   match_in[0] = item.write_data[COUNT_BITS-1:0];
               REG_MATCH1:   match_in[1] = item.write_data[COUNT_BITS-1:0];
               REG_MATCH2:   match_in[2] = item.write_data[COUNT_BITS-1:0];
               REG_ENABLE:   enable_in   = item.write_data[ENABLE_W-1:0];
               default:      ;
            endcase
         end
         default: ;
      endcase

      if (adv) begin
         cnt_in = cnt_adv;
         // wrap clears the wave first, match 0 may set it again
         if (adv_wrap) begin
            if (cnt_ctrl_ff[CT_INTV_BIT]) begin
               status_in[IS_INTV_BIT] = 1'b1;
            end else begin
               status_in[IS_OVR_BIT] = 1'b1;
            end
            wave_in = 1'b0;
         end
         if (cnt_ctrl_ff[CT_MATCH_BIT]) begin
            for (int i = 0; i < MATCH_NUM; i++) begin
               if (hit[i]) begin
                  status_in[IS_MATCH0_BIT + i] = 1'b1;
               end
            end
            if (hit[0]) begin
               wave_in = 1'b1;
            end
         end
      end

      result.read_data = rd;
      result.irq       = |(status_in & enable_in[STATUS_W-1:0]);
      result.wave_out  = cnt_ctrl_in[CT_WAVE_DIS_BIT] ? cnt_ctrl_in[CT_POL_BIT]
                                                      : (wave_in ^ cnt_ctrl_in[CT_POL_BIT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff       <= '0;
         cnt_ff      <= '0;
         clk_ctrl_ff <= '0;
         cnt_ctrl_ff <= CNT_CTRL_W'(1) << CT_STOP_BIT;
         interval_ff <= '0;
         for (int i = 0; i < MATCH_NUM; i++) begin
            match_ff[i] <= '0;
         end
         status_ff   <= '0;
         enable_ff   <= '0;
         wave_ff     <= 1'b0;
      end else if (fire) begin
         ps_ff       <= ps_in;
         cnt_ff      <= cnt_in;
         clk_ctrl_ff <= clk_ctrl_in;
         cnt_ctrl_ff <= cnt_ctrl_in;
         interval_ff <= interval_in;
         match_ff    <= match_in;
         status_ff   <= status_in;
         enable_ff   <= enable_in;
         wave_ff     <= wave_in;
      end
   end

   `TCM_ASSERT_NEXT(a_stop_holds, !reset && fire && item.kind == KIND_TICK && cnt_ctrl_ff[CT_STOP_BIT], $stable(cnt_ff) && $stable(ps_ff), "stopped counter moved")
   `TCM_ASSERT_NEXT(a_status_clear, !reset && fire && item.kind == KIND_READ && item.reg_index == REG_STATUS, status_ff == '0, "status not cleared by read")
   `TCM_ASSERT_NEXT(a_idle_hold, !reset && !fire, $stable(cnt_ff) && $stable(status_ff), "state changed without a transaction")

endmodule

>>> rtl/tcm_out_reg.sv
module tcm_out_reg
   import tcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  rsp_item_type result,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // pipeline moves when the result slot is empty or being taken
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

>>> dv/timer_counter_with_match_top_tb.sv
`timescale 1ns / 100ps

module timer_counter_with_match_top_tb;
   import tcm_pkg::*;

   localparam int COUNT_W          = 16;
   localparam int PRESCALE_W       = 4;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_PER_PHASE = 140;
   localparam int SETTLE_CYCLES    = 4;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   // kind code the block has to ignore
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   localparam logic [DATA_W-1:0] CLK_PS_EN = 1 << CC_PS_EN_BIT;
   localparam logic [DATA_W-1:0] CTL_STOP  = 1 << CT_STOP_BIT;
   localparam logic [DATA_W-1:0] CTL_INTV  = 1 << CT_INTV_BIT;
   localparam logic [DATA_W-1:0] CTL_DECR  = 1 << CT_DECR_BIT;
   localparam logic [DATA_W-1:0] CTL_MATCH = 1 << CT_MATCH_BIT;
   localparam logic [DATA_W-1:0] CTL_POL   = 1 << CT_POL_BIT;

   class timer_tracker;
      logic [15:0]           presc_q;
      logic [COUNT_W-1:0]    count_q;
      logic [CLK_CTRL_W-1:0] clk_ctrl_q;
      logic [CNT_CTRL_W-1:0] cnt_ctrl_q;
      logic [COUNT_W-1:0]    interval_q;
      logic [COUNT_W-1:0]    match_q [MATCH_NUM];
      logic [STATUS_W-1:0]   status_q;
      logic [ENABLE_W-1:0]   enable_q;
      logic                  wave_q;
      rsp_item_type          expected_rsp [$];
      int unsigned           ticks, reads, writes, others, compared, wraps, hits;
      int unsigned           mismatches;

      function new();
         presc_q    = '0;
         count_q    = '0;
         clk_ctrl_q = '0;
         cnt_ctrl_q = '0;
         cnt_ctrl_q[CT_STOP_BIT] = 1'b1;
         interval_q = '0;
         foreach (match_q[i]) match_q[i] = '0;
         status_q   = '0;
         enable_q   = '0;
         wave_q     = 1'b0;
      endfunction

      function void advance_count();
         logic [COUNT_W-1:0] top;
         logic               wrapped;
         int                 i;
         top     = cnt_ctrl_q[CT_INTV_BIT] ? interval_q : '1;
         wrapped = 1'b0;
         if (cnt_ctrl_q[CT_DECR_BIT]) begin
            if (count_q == '0) begin
               count_q = top;
               wrapped = 1'b1;
            end else begin
               count_q = count_q - COUNT_W'(1);
            end
         end else begin
            // a count above the top wraps as well
            if (count_q >= top) begin
               count_q = '0;
               wrapped = 1'b1;
            end else begin
               count_q = count_q + COUNT_W'(1);
            end
         end
         if (wrapped) begin
            status_q[cnt_ctrl_q[CT_INTV_BIT] ? IS_INTV_BIT : IS_OVR_BIT] = 1'b1;
            wave_q = 1'b0;
            wraps++;
         end
         // match 0 wins over a wrap on the same tick
         if (cnt_ctrl_q[CT_MATCH_BIT]) begin
            for (i = 0; i < MATCH_NUM; i++) begin
               if (count_q == match_q[i]) begin
                  status_q[IS_MATCH0_BIT + i] = 1'b1;
                  if (i == 0) wave_q = 1'b1;
                  hits++;
               end
            end
         end
      endfunction

      function void tick();
         int unsigned span;
         if (cnt_ctrl_q[CT_STOP_BIT]) return;
         if (clk_ctrl_q[CC_PS_EN_BIT]) begin
            span = 32'd1 << (clk_ctrl_q[PRESCALE_W:1] + 1);
            if (32'(presc_q) + 1 >= span) begin
               presc_q = '0;
               advance_count();
            end else begin
               presc_q = presc_q + 16'(1);
            end
         end else begin
            presc_q = '0;
            advance_count();
         end
      endfunction

      function logic [DATA_W-1:0] read_reg(logic [INDEX_W-1:0] idx);
         logic [DATA_W-1:0] value;
         value = '0;
         case (idx)
            REG_CLK_CTRL: value = DATA_W'(clk_ctrl_q);
            REG_CNT_CTRL: value = DATA_W'(cnt_ctrl_q);
            REG_COUNT:    value = DATA_W'(count_q);
            REG_INTERVAL: value = DATA_W'(interval_q);
            REG_MATCH0:   value = DATA_W'(match_q[0]);
            REG_MATCH1:   value = DATA_W'(match_q[1]);
            REG_MATCH2:   value = DATA_W'(match_q[2]);
            REG_STATUS: begin
               value    = DATA_W'(status_q);
               status_q = '0;
            end
            REG_ENABLE:   value = DATA_W'(enable_q);
            default:      value = '0;
         endcase
         return value;
      endfunction

      function void write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            REG_CLK_CTRL: clk_ctrl_q = data[CLK_CTRL_W-1:0];
            REG_CNT_CTRL: begin
               cnt_ctrl_q = data[CNT_CTRL_W-1:0];
               if (cnt_ctrl_q[CT_RST_BIT]) begin
                  count_q = '0;
                  presc_q = '0;
                  cnt_ctrl_q[CT_RST_BIT] = 1'b0;
               end
            end
            REG_INTERVAL: interval_q = data[COUNT_W-1:0];
            REG_MATCH0:   match_q[0] = data[COUNT_W-1:0];
            REG_MATCH1:   match_q[1] = data[COUNT_W-1:0];
            REG_MATCH2:   match_q[2] = data[COUNT_W-1:0];
            REG_ENABLE:   enable_q = data[ENABLE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                 logic [DATA_W-1:0] data);
         rsp_item_type exp;
         exp = '0;
         case (kind)
            KIND_TICK: begin
               tick();
               ticks++;
            end
            KIND_READ: begin
               exp.read_data = read_reg(idx);
               reads++;
            end
            KIND_WRITE: begin
               write_reg(idx, data);
               writes++;
            end
            default: others++;
         endcase
         exp.irq      = |({1'b0, status_q} & enable_q);
         exp.wave_out = cnt_ctrl_q[CT_WAVE_DIS_BIT] ? cnt_ctrl_q[CT_POL_BIT]
                                                    : (wave_q ^ cnt_ctrl_q[CT_POL_BIT]);
         expected_rsp.push_back(exp);
      endfunction

      function void check_response(logic [DATA_W-1:0] rd, logic irq, logic wave);
         rsp_item_type exp;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with nothing outstanding: read_data %h irq %b wave %b",
                        $time, rd, irq, wave);
            return;
         end
         exp = expected_rsp.pop_front();
         compared++;
         if (rd !== exp.read_data || irq !== exp.irq || wave !== exp.wave_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"%0t: response %0d mismatch: read_data exp %h got %h, ",
                         "irq exp %b got %b, wave_out exp %b got %b"},
                        $time, compared, exp.read_data, rd, exp.irq, irq,
                        exp.wave_out, wave);
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind       = KIND_TICK;
   logic [INDEX_W-1:0]  req_reg_index  = REG_CLK_CTRL;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_irq;
   logic                rsp_wave_out;

   timer_tracker tracker;
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  cycle_count    = 0;

   timer_counter_with_match_top #(
      .COUNT_BITS    (COUNT_W),
      .PRESCALE_BITS (PRESCALE_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq),
      .rsp_wave_out   (rsp_wave_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // response side: compare on every taken transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_read_data, rsp_irq, rsp_wave_out);
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                               input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_reg_index  <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(kind, idx, data);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // mostly ticks on a running counter with small interval and match values
   task automatic pick_request(output logic [KIND_W-1:0] kind, output logic [INDEX_W-1:0] idx,
                               output logic [DATA_W-1:0] data);
      int unsigned sel;
      int unsigned wsel;
      sel  = $urandom_range(99);
      wsel = $urandom_range(99);
      kind = KIND_TICK;
      idx  = INDEX_W'($urandom);
      data = $urandom;
      if (sel < 62) begin
         kind = KIND_TICK;
      end else if (sel < 78) begin
         kind = KIND_READ;
         if ($urandom_range(19) == 0) idx = INDEX_W'($urandom_range(9, 15));
         else                         idx = INDEX_W'($urandom_range(0, 8));
      end else if (sel < 98) begin
         kind = KIND_WRITE;
         if (wsel < 15) begin
            idx = REG_CLK_CTRL;
            if ($urandom_range(9) != 0) data[4:1] = 4'($urandom_range(0, 2));
         end else if (wsel < 35) begin
            idx = REG_CNT_CTRL;
            data[CT_STOP_BIT]  = ($urandom_range(9) == 0);
            data[CT_RST_BIT]   = ($urandom_range(5) == 0);
            data[CT_MATCH_BIT] = ($urandom_range(3) != 0);
         end else if (wsel < 50) begin
            idx = REG_INTERVAL;
            if ($urandom_range(7) != 0) data[15:0] = 16'($urandom_range(0, 24));
         end else if (wsel < 75) begin
            idx = REG_MATCH0 + INDEX_W'($urandom_range(2));
            if ($urandom_range(7) != 0) data[15:0] = 16'($urandom_range(0, 24));
         end else if (wsel < 88) begin
            idx = REG_ENABLE;
         end else if (wsel < 92) begin
            idx = REG_COUNT;
         end else if (wsel < 96) begin
            idx = REG_STATUS;
         end else begin
            idx = INDEX_W'($urandom_range(9, 15));
         end
      end else begin
         kind = KIND_NONE;
      end
   endtask

   initial begin
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] idx;
      logic [DATA_W-1:0]  data;
      int                 phase;

      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, both wrap directions, clear on read, reset bit, ignored items
      send_request(KIND_READ,  REG_CNT_CTRL, '0);
      send_request(KIND_TICK,  REG_CLK_CTRL, '0);
      send_request(KIND_WRITE, REG_ENABLE,   32'hffff_ffff);
      send_request(KIND_WRITE, REG_MATCH0,   32'h0000_ffff);
      send_request(KIND_WRITE, REG_CNT_CTRL, CTL_DECR | CTL_MATCH);
      send_request(KIND_TICK,  REG_CLK_CTRL, '0);
      send_request(KIND_READ,  REG_COUNT,    '0);
      send_request(KIND_WRITE, REG_CNT_CTRL, CTL_MATCH);
      send_request(KIND_TICK,  REG_CLK_CTRL, '0);
      send_request(KIND_READ,  REG_STATUS,   '0);
      send_request(KIND_READ,  REG_STATUS,   '0);
      send_request(KIND_WRITE, REG_MATCH1,   '0);
      send_request(KIND_WRITE, REG_MATCH2,   32'h0000_0002);
      send_request(KIND_WRITE, REG_INTERVAL, 32'h0000_0002);
      send_request(KIND_WRITE, REG_CLK_CTRL, CLK_PS_EN);
      send_request(KIND_WRITE, REG_CNT_CTRL, CTL_INTV | CTL_MATCH | CTL_POL);
      repeat (6) send_request(KIND_TICK, REG_CLK_CTRL, '0);
      send_request(KIND_WRITE, REG_CNT_CTRL, 32'hffff_ffff);
      send_request(KIND_READ,  REG_CNT_CTRL, '0);
      send_request(KIND_WRITE, REG_COUNT,    32'h0000_1234);
      send_request(KIND_WRITE, REG_STATUS,   32'hffff_ffff);
      send_request(KIND_NONE,  4'hf,         32'hffff_ffff);
      send_request(KIND_READ,  4'hf,         '0);
      send_request(KIND_WRITE, REG_INTERVAL, 32'hffff_ffff);
      send_request(KIND_WRITE, REG_CLK_CTRL, 32'hffff_ffff);
      send_request(KIND_READ,  REG_CLK_CTRL, '0);

      for (phase = 0; phase < 3; phase++) begin
         // hold off until the block has answered everything outstanding
         wait_for_responses();
         case (phase)
            0: begin
               send_idle_pct  = 9;
               recv_stall_pct = 61;
            end
            1: begin
               send_idle_pct  = 61;
               recv_stall_pct = 9;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            pick_request(kind, idx, data);
            send_request(kind, idx, data);
         end
      end

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d transactions: %0d ticks, %0d reads, %0d writes, %0d of unknown kind",
               tracker.ticks + tracker.reads + tracker.writes + tracker.others,
               tracker.ticks, tracker.reads, tracker.writes, tracker.others);
      $display("%0d responses compared, %0d counter wraps, %0d match hits, %0d mismatches",
               tracker.compared, tracker.wraps, tracker.hits, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
